/* src/p24_pkg.sv */
// Shared constants, tables, types and round functions of the 24-bit block decryptor.
`default_nettype none
package p24_pkg;

    localparam int ROUNDS   = 10;
    localparam int NUM_KEYS = ROUNDS + 1;
    localparam int BLOCK_W  = 24;
    localparam int SLOT_W   = 4;
    localparam int ID_W     = $clog2(NUM_KEYS);
    localparam int CMP_W    = (ID_W > SLOT_W) ? ID_W : SLOT_W;
    localparam int NIBBLES  = BLOCK_W / 4;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [3:0] INV_SBOX [16] = '{
        4'd5, 4'd14, 4'd15, 4'd8, 4'd12, 4'd1, 4'd2, 4'd13,
        4'd11, 4'd4, 4'd6, 4'd3, 4'd0, 4'd7, 4'd9, 4'd10
    };

    localparam logic [4:0] INV_PERM [BLOCK_W] = '{
        5'd0, 5'd4, 5'd8, 5'd12, 5'd16, 5'd20, 5'd1, 5'd5, 5'd9, 5'd13, 5'd17, 5'd21,
        5'd2, 5'd6, 5'd10, 5'd14, 5'd18, 5'd22, 5'd3, 5'd7, 5'd11, 5'd15, 5'd19, 5'd23
    };

    // Control that travels with every item along the chain.
    typedef struct packed {
        logic              valid;
        logic              command;
        logic [SLOT_W-1:0] key_slot;
    } t_ctl;

    function automatic logic [BLOCK_W-1:0] inv_permute(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int i = 0; i < BLOCK_W; i++) begin
            y[INV_PERM[i]] = x[i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] inv_substitute(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y = '0;
        for (int n = 0; n < NIBBLES; n++) begin
            y[4*n +: 4] = INV_SBOX[x[4*n +: 4]];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

/* src/p24_round_cell.sv */
// One cell of the decryption chain: holds one round key and applies one round.
`default_nettype none
module p24_round_cell (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_advance,
    input  wire logic                          i_whiten,
    input  wire logic [p24_pkg::ID_W-1:0]      i_slot_id,
    input  wire p24_pkg::t_ctl                 i_ctl,
    input  wire logic [p24_pkg::BLOCK_W-1:0]   i_data,
    output p24_pkg::t_ctl                      o_ctl,
    output logic [p24_pkg::BLOCK_W-1:0]        o_data
);

    logic [p24_pkg::BLOCK_W-1:0] r_key;
    logic                        r_valid;
    logic                        r_command;
    logic [p24_pkg::SLOT_W-1:0]  r_key_slot;
    logic [p24_pkg::BLOCK_W-1:0] r_data;
    logic [p24_pkg::BLOCK_W-1:0] n_data;
    logic                        slot_hit;

    assign slot_hit = (p24_pkg::CMP_W'(i_ctl.key_slot) == p24_pkg::CMP_W'(i_slot_id));

    // The first cell only adds the last round key; the others run a full round.
    always_comb begin
        if (i_whiten) begin
            n_data = i_data ^ r_key;
        end else begin
            n_data = p24_pkg::inv_substitute(p24_pkg::inv_permute(i_data)) ^ r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    // A load item updates the key as it passes, so items ahead of it keep the old key.
    always_ff @(posedge i_clk) begin
        if (i_advance && i_ctl.valid && i_ctl.command == p24_pkg::CMD_LOAD && slot_hit) begin
            r_key <= i_data;
        end
        if (i_advance) begin
            r_command  <= i_ctl.command;
            r_key_slot <= i_ctl.key_slot;
            r_data     <= (i_ctl.command == p24_pkg::CMD_DECRYPT) ? n_data : i_data;
        end
    end

    assign o_ctl.valid    = r_valid;
    assign o_ctl.command  = r_command;
    assign o_ctl.key_slot = r_key_slot;
    assign o_data         = r_data;

endmodule
`default_nettype wire

/* src/present24_block_decrypt.sv */
// The chain has one registered cell per round key; an accepted decrypt item passes every
// cell before its plaintext appears. It takes one item per cycle while the output is not stalled.
// Load items travel the chain too and write their key in the owning cell.
// The whole chain stalls only while a finished plaintext waits at the output.
// Reset clears the valid flags; round keys are undefined until loaded.
`default_nettype none
module present24_block_decrypt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic                          i_command,
    input  wire logic [p24_pkg::SLOT_W-1:0]    i_key_slot,
    input  wire logic [p24_pkg::BLOCK_W-1:0]   i_data_word,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [p24_pkg::BLOCK_W-1:0]        o_plain_block
);

    localparam int STAGES = p24_pkg::NUM_KEYS;

    p24_pkg::t_ctl               ctl  [STAGES+1];
    logic [p24_pkg::BLOCK_W-1:0] data [STAGES+1];
    logic                        advance;

    assign ctl[0].valid    = i_in_valid;
    assign ctl[0].command  = i_command;
    assign ctl[0].key_slot = i_key_slot;
    assign data[0]         = i_data_word;

    // Load items leaving the chain are dropped, so only a waiting plaintext blocks it.
    assign o_out_valid   = ctl[STAGES].valid && (ctl[STAGES].command == p24_pkg::CMD_DECRYPT);
    assign o_plain_block = data[STAGES];
    assign advance       = !o_out_valid || i_out_ready;
    assign o_in_ready    = advance;

    for (genvar s = 0; s < STAGES; s++) begin : g_cell
        p24_round_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_advance (advance),
            .i_whiten  ((s == 0) ? 1'b1 : 1'b0),
            .i_slot_id (p24_pkg::ID_W'(p24_pkg::ROUNDS - s)),
            .i_ctl     (ctl[s]),
            .i_data    (data[s]),
            .o_ctl     (ctl[s+1]),
            .o_data    (data[s+1])
        );
    end

endmodule
`default_nettype wire

/* test/present24_block_decrypt_tb.sv */
// Self-checking testbench for the 24-bit block decryptor with its loadable round-key store.
`timescale 1ns / 100ps

module present24_block_decrypt_tb;

    // Keeps its own copy of the round keys and the plaintexts still owed by the block.
    class plain_scoreboard;
        localparam int          KEY_COUNT = 11;
        // Inverse S-box, entry n in bits 4n+3..4n.
        localparam logic [63:0] SBOX_INV  = 64'hA970_364B_D21C_8FE5;

        logic [23:0] round_key [KEY_COUNT];
        logic [23:0] pending_plain [$];
        int          mismatches;

        function new();
            mismatches = 0;
            foreach (round_key[k]) round_key[k] = '0;
        endfunction

        function logic [23:0] decipher(logic [23:0] block);
            logic [23:0] s;
            logic [23:0] moved;
            s = block ^ round_key[KEY_COUNT-1];
            for (int r = KEY_COUNT - 2; r >= 0; r--) begin
                // Bit i lands on 4*(i mod 6) + i div 6.
                for (int i = 0; i < 24; i++) begin
                    moved[4*(i%6) + i/6] = s[i];
                end
                for (int n = 0; n < 6; n++) begin
                    s[4*n +: 4] = SBOX_INV[4*moved[4*n +: 4] +: 4];
                end
                s = s ^ round_key[r];
            end
            return s;
        endfunction

        function void note_item(logic cmd, logic [3:0] slot, logic [23:0] word);
            if (cmd == p24_pkg::CMD_LOAD) begin
                if (slot < KEY_COUNT) round_key[slot] = word;
            end else begin
                pending_plain.push_back(decipher(word));
            end
        endfunction

        task report(string msg);
            $display("ERROR at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_plain(logic [23:0] got);
            logic [23:0] want;
            if (pending_plain.size() == 0) begin
                report($sformatf("plain block %06h with no decrypt item pending", got));
            end else begin
                want = pending_plain.pop_front();
                if (got !== want) begin
                    report($sformatf("plain block %06h, expected %06h", got, want));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [3:0]  i_key_slot;
    logic [23:0] i_data_word;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [23:0] o_plain_block;

    plain_scoreboard sb = new();
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off       = 1'b0;

    present24_block_decrypt DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key_slot    (i_key_slot),
        .i_data_word   (i_data_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_plain_block (o_plain_block)
    );

    always #5 i_clk = ~i_clk;

    // Output side: check what was taken at this edge, then choose the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_plain(o_plain_block);
        end
        if (hold_off) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task send_item(input logic cmd, input logic [3:0] slot, input logic [23:0] word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_key_slot  <= slot;
        i_data_word <= word;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(cmd, slot, word);
    endtask

    function logic [23:0] pick_word();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) return 24'h000000;
        if (pick == 1) return 24'hFFFFFF;
        return 24'($urandom());
    endfunction

    // Mostly decrypts; key reloads now and then, and the odd load to a slot past the store.
    task run_random(input int count);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            if (roll < 84) begin
                send_item(p24_pkg::CMD_DECRYPT, 4'($urandom_range(15)), pick_word());
            end else if (roll < 97) begin
                send_item(p24_pkg::CMD_LOAD, 4'($urandom_range(10)), pick_word());
            end else begin
                send_item(p24_pkg::CMD_LOAD, 4'($urandom_range(15, 11)), pick_word());
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_command   <= p24_pkg::CMD_LOAD;
        i_key_slot  <= '0;
        i_data_word <= '0;
        i_out_ready <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every key is loaded before the first decrypt reads the store.
        send_item(p24_pkg::CMD_LOAD, 4'd0,  24'h000000);
        send_item(p24_pkg::CMD_LOAD, 4'd1,  24'hFFFFFF);
        send_item(p24_pkg::CMD_LOAD, 4'd2,  24'h555555);
        send_item(p24_pkg::CMD_LOAD, 4'd3,  24'hAAAAAA);
        send_item(p24_pkg::CMD_LOAD, 4'd4,  24'h000001);
        send_item(p24_pkg::CMD_LOAD, 4'd5,  24'h800000);
        send_item(p24_pkg::CMD_LOAD, 4'd6,  24'h123456);
        send_item(p24_pkg::CMD_LOAD, 4'd7,  24'hFEDCBA);
        send_item(p24_pkg::CMD_LOAD, 4'd8,  24'h0F0F0F);
        send_item(p24_pkg::CMD_LOAD, 4'd9,  24'hF0F0F0);
        send_item(p24_pkg::CMD_LOAD, 4'd10, 24'hFFFFFF);
        // Slots past the store must leave every key untouched.
        send_item(p24_pkg::CMD_LOAD, 4'd11, 24'h000000);
        send_item(p24_pkg::CMD_LOAD, 4'd15, 24'h5A5A5A);
        // The slot field means nothing to a decrypt.
        send_item(p24_pkg::CMD_DECRYPT, 4'd15, 24'h000000);
        send_item(p24_pkg::CMD_DECRYPT, 4'd0,  24'hFFFFFF);
        send_item(p24_pkg::CMD_DECRYPT, 4'd10, 24'h555555);
        send_item(p24_pkg::CMD_DECRYPT, 4'd5,  24'hAAAAAA);
        // Loads and decrypts back to back: a key change takes effect from the next item on.
        send_item(p24_pkg::CMD_LOAD,    4'd10, 24'h000000);
        send_item(p24_pkg::CMD_DECRYPT, 4'd0,  24'hFFFFFF);
        send_item(p24_pkg::CMD_DECRYPT, 4'd0,  24'h3C3C3C);
        send_item(p24_pkg::CMD_LOAD,    4'd0,  24'hC0FFEE);
        send_item(p24_pkg::CMD_DECRYPT, 4'd12, 24'h3C3C3C);

        run_random(400);
        send_idle_pct = 78;
        run_random(400);
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        run_random(400);
        send_idle_pct  = 8;
        recv_stall_pct = 8;
        run_random(350);

        // Long hold-off at the output while items keep coming, so the chain backs up.
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        run_random(100);

        i_in_valid     <= 1'b0;
        recv_stall_pct = 0;
        while (sb.pending_plain.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending_plain.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
